// ===== hw/rtl/lsatc_pkg.sv =====
// Shared constants, codes and helpers for the line sensor threshold block.
// No dependencies; the top-level block and lsatc_alu use this package.
`default_nettype none

package lsatc_pkg;

   // Build-time sizing
   localparam int SENSOR_COUNT  = 16;
   localparam int HISTORY_DEPTH = 10;
   localparam int SAMPLE_BITS   = 12;
   localparam int BAR_STEP      = 256;

   // Port field widths (fixed by the interface)
   localparam int OP_BITS     = 2;
   localparam int CH_BITS     = 4;
   localparam int IN_SMP_BITS = 12;
   localparam int POS_BITS    = 4;
   localparam int AVG_BITS    = 12;
   localparam int BAR_BITS    = 5;
   localparam int FRAME_BITS  = 16;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 9;
   localparam int FACTOR_BITS   = 9;

   localparam int CI_BITS   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int SLOT_BITS = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HIST_ADDR_BITS = CI_BITS + SLOT_BITS;
   localparam int HIST_WORDS     = 2 ** HIST_ADDR_BITS;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] THR_RESET  = SAMPLE_MAX >> 1;

   // Shared multiplier operand widths
   localparam int MUL_B_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS  = SAMPLE_BITS + MUL_B_BITS;

   // Reciprocals for divide-by-constant (floor, one correction step after)
   localparam logic [MUL_B_BITS-1:0] HIST_RECIP =
      MUL_B_BITS'((2 ** SAMPLE_BITS) / HISTORY_DEPTH);
   localparam logic [MUL_B_BITS-1:0] BAR_RECIP =
      MUL_B_BITS'((2 ** SAMPLE_BITS) / BAR_STEP);

   localparam logic [FACTOR_BITS-1:0] FACTOR_ONE   = 9'd256;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 9'd128;
   localparam logic [BAR_BITS-1:0]    BAR_MAX      = 5'd16;
   localparam int FRAC_BITS = 8;

   // Command codes
   typedef enum logic [OP_BITS-1:0] {
      OP_SAMPLE    = 2'd0,
      OP_CAL_START = 2'd1,
      OP_CAL_APPLY = 2'd2,
      OP_CAL_DROP  = 2'd3
   } op_type;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_POLARITY = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FACTOR   = 1'd1;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_HRD  = 9'b000000010,
      ST_OLDQ = 9'b000000100,
      ST_NEWQ = 9'b000001000,
      ST_DET  = 9'b000010000,
      ST_BAR  = 9'b000100000,
      ST_FIN  = 9'b001000000,
      ST_APP  = 9'b010000000,
      ST_APW  = 9'b100000000
   } state_type;

   // Quotient from reciprocal product, corrected by at most one
   function automatic logic [SAMPLE_BITS-1:0] fix_quot(
      input logic [SAMPLE_BITS-1:0] x,
      input logic [PROD_BITS-1:0]   prod,
      input int                     d
   );
      logic [31:0] est;
      logic [31:0] rem;
      est = 32'(prod >> SAMPLE_BITS);
      rem = 32'(x) - est * 32'(d);
      if (rem >= 32'(d)) begin
         est = est + 32'd1;
      end
      return SAMPLE_BITS'(est);
   endfunction

   // DMA channel to physical position
   function automatic logic [CI_BITS-1:0] pos_of(input logic [CI_BITS-1:0] ch);
      logic [CI_BITS-1:0] half;
      half = ch >> 1;
      if (ch[0] == 1'b0) begin
         return CI_BITS'(SENSOR_COUNT - 1) - half;
      end
      return half;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/line_sensor_array_threshold_calibrate.sv =====
// Line sensor array: moving-average filter, threshold detect, min/max calibration.
// Depends on lsatc_pkg, lsatc_ram, lsatc_alu.
//
// One command word in, one result word out. A sample word passes states HRD,
// OLDQ, NEWQ, DET, BAR and FIN from accept to result (history RAM read, two
// reciprocal divides and one bar divide, the divides through a single shared
// multiplier). Start and discard commands answer in the cycle after accept.
// Apply walks every position through the multiplier in states APP and APW. One
// word is in flight at a time; a new word is taken only when the sequencer is
// idle and the result register is free or being drained. The filter keeps a
// running sum of truncated tenths per channel, so no pass over the history is
// needed; history entries start as zero via valid bits, with no clear after reset.
`default_nettype none

module line_sensor_array_threshold_calibrate (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // command channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [lsatc_pkg::OP_BITS-1:0]      req_operation,
   input  wire logic [lsatc_pkg::CH_BITS-1:0]      req_channel,
   input  wire logic [lsatc_pkg::IN_SMP_BITS-1:0]  req_sample,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [lsatc_pkg::POS_BITS-1:0]     rsp_position,
   output logic      [lsatc_pkg::AVG_BITS-1:0]     rsp_average,
   output logic                                    rsp_detected,
   output logic      [lsatc_pkg::BAR_BITS-1:0]     rsp_bar_level,
   output logic      [lsatc_pkg::FRAME_BITS-1:0]   rsp_frame_bits,
   output logic                                    rsp_frame_done,
   output logic                                    rsp_calibrating,
   // register writes
   input  wire logic                               csr_wen,
   input  wire logic [lsatc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [lsatc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SB = lsatc_pkg::SAMPLE_BITS;
   localparam int CB = lsatc_pkg::CI_BITS;
   localparam int NS = lsatc_pkg::SENSOR_COUNT;

   // control state
   lsatc_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 track_ff, track_in;
   logic                 polarity_ff, polarity_in;
   logic [lsatc_pkg::FACTOR_BITS-1:0] factor_ff, factor_in;
   logic [lsatc_pkg::SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [lsatc_pkg::FRAME_BITS-1:0]  acc_ff, acc_in;
   logic [lsatc_pkg::HIST_WORDS-1:0]  hvld_ff, hvld_in;
   logic [SB-1:0] sum_ff   [NS];
   logic [SB-1:0] sum_in   [NS];
   logic [SB-1:0] thr_ff   [NS];
   logic [SB-1:0] thr_in   [NS];
   logic [SB-1:0] upper_ff [NS];
   logic [SB-1:0] upper_in [NS];
   logic [SB-1:0] lower_ff [NS];
   logic [SB-1:0] lower_in [NS];

   // working payload
   logic [CB-1:0] ch_ff, ch_in;
   logic [CB-1:0] pos_ff, pos_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic [SB-1:0] smp_ff, smp_in;
   logic [SB-1:0] old_ff, old_in;
   logic [SB-1:0] qold_ff, qold_in;
   logic [SB-1:0] avg_ff, avg_in;
   logic [SB-1:0] diff_ff, diff_in;
   logic          det_ff, det_in;
   logic          oldv_ff, oldv_in;

   // result register
   logic [lsatc_pkg::POS_BITS-1:0]   o_pos_ff, o_pos_in;
   logic [lsatc_pkg::AVG_BITS-1:0]   o_avg_ff, o_avg_in;
   logic                             o_det_ff, o_det_in;
   logic [lsatc_pkg::BAR_BITS-1:0]   o_bar_ff, o_bar_in;
   logic [lsatc_pkg::FRAME_BITS-1:0] o_bits_ff, o_bits_in;
   logic                             o_done_ff, o_done_in;
   logic                             o_cal_ff, o_cal_in;

   // history RAM and multiplier hookup
   logic                                   h_wr_en, h_rd_en;
   logic [lsatc_pkg::HIST_ADDR_BITS-1:0]   h_wr_addr, h_rd_addr;
   logic [SB-1:0]                          h_rd_data;
   logic [SB-1:0]                          mul_a;
   logic [lsatc_pkg::MUL_B_BITS-1:0]       mul_b;
   logic [lsatc_pkg::PROD_BITS-1:0]        prod;

   logic accept;
   logic out_free;

   lsatc_ram #(
      .WIDTH (SB),
      .DEPTH (lsatc_pkg::HIST_WORDS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (smp_ff),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   lsatc_alu u_alu (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // result slot drains this cycle or is empty
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != lsatc_pkg::ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = o_pos_ff;
   assign rsp_average     = o_avg_ff;
   assign rsp_detected    = o_det_ff;
   assign rsp_bar_level   = o_bar_ff;
   assign rsp_frame_bits  = o_bits_ff;
   assign rsp_frame_done  = o_done_ff;
   assign rsp_calibrating = o_cal_ff;

   always_comb begin
      logic [CB-1:0]  chi;
      logic [SB-1:0]  qnew;
      logic [SB-1:0]  avg;
      logic [SB-1:0]  th;
      logic [SB-1:0]  quot;
      logic [SB:0]    bq;
      logic [lsatc_pkg::FACTOR_BITS-1:0] f;
      logic [3:0]     bit_idx;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      track_in     = track_ff;
      polarity_in  = polarity_ff;
      factor_in    = factor_ff;
      slot_in      = slot_ff;
      acc_in       = acc_ff;
      hvld_in      = hvld_ff;
      sum_in       = sum_ff;
      thr_in       = thr_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      ch_in        = ch_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      smp_in       = smp_ff;
      old_in       = old_ff;
      qold_in      = qold_ff;
      avg_in       = avg_ff;
      diff_in      = diff_ff;
      det_in       = det_ff;
      oldv_in      = oldv_ff;
      o_pos_in     = o_pos_ff;
      o_avg_in     = o_avg_ff;
      o_det_in     = o_det_ff;
      o_bar_in     = o_bar_ff;
      o_bits_in    = o_bits_ff;
      o_done_in    = o_done_ff;
      o_cal_in     = o_cal_ff;

      h_wr_en   = 1'b0;
      h_rd_en   = 1'b0;
      h_wr_addr = {ch_ff, slot_ff};
      h_rd_addr = {CB'(req_channel), slot_ff};
      mul_a     = '0;
      mul_b     = lsatc_pkg::HIST_RECIP;

      chi  = CB'(req_channel);
      qnew = '0;
      avg  = '0;
      th   = thr_ff[pos_ff];
      quot = '0;
      bq   = '0;
      f    = (factor_ff > lsatc_pkg::FACTOR_ONE) ? lsatc_pkg::FACTOR_ONE : factor_ff;
      bit_idx = 4'(NS - 1) - 4'(pos_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         unique case (csr_index)
            lsatc_pkg::REG_POLARITY: polarity_in = csr_wdata[0];
            lsatc_pkg::REG_FACTOR:   factor_in   = lsatc_pkg::FACTOR_BITS'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         lsatc_pkg::ST_IDLE: begin
            if (accept) begin
               // default answer: all-zero fields but the calibrating flag
               o_pos_in  = '0;
               o_avg_in  = '0;
               o_det_in  = 1'b0;
               o_bar_in  = '0;
               o_bits_in = '0;
               o_done_in = 1'b0;
               o_cal_in  = track_ff;
               case (lsatc_pkg::op_type'(req_operation))
                  lsatc_pkg::OP_SAMPLE: begin
                     if (32'(req_channel) < NS) begin
                        h_rd_en  = 1'b1;
                        ch_in    = chi;
                        smp_in   = SB'(req_sample);
                        oldv_in  = hvld_ff[{chi, slot_ff}];
                        state_in = lsatc_pkg::ST_HRD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  lsatc_pkg::OP_CAL_START: begin
                     if (!track_ff) begin
                        for (int j = 0; j < NS; j++) begin
                           upper_in[j] = '0;
                           lower_in[j] = lsatc_pkg::SAMPLE_MAX;
                        end
                        track_in = 1'b1;
                     end
                     o_cal_in     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  lsatc_pkg::OP_CAL_APPLY: begin
                     if (track_ff) begin
                        idx_in   = '0;
                        state_in = lsatc_pkg::ST_APP;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     track_in     = 1'b0;
                     o_cal_in     = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         lsatc_pkg::ST_HRD: begin
            // entry never written reads as zero
            old_in  = oldv_ff ? h_rd_data : '0;
            mul_a   = old_in;
            h_wr_en = 1'b1;
            hvld_in[{ch_ff, slot_ff}] = 1'b1;
            state_in = lsatc_pkg::ST_OLDQ;
         end
         lsatc_pkg::ST_OLDQ: begin
            qold_in  = lsatc_pkg::fix_quot(old_ff, prod, lsatc_pkg::HISTORY_DEPTH);
            mul_a    = smp_ff;
            state_in = lsatc_pkg::ST_NEWQ;
         end
         lsatc_pkg::ST_NEWQ: begin
            qnew = lsatc_pkg::fix_quot(smp_ff, prod, lsatc_pkg::HISTORY_DEPTH);
            avg  = sum_ff[ch_ff] - qold_ff + qnew;
            sum_in[ch_ff] = avg;
            avg_in   = avg;
            pos_in   = lsatc_pkg::pos_of(ch_ff);
            state_in = lsatc_pkg::ST_DET;
         end
         lsatc_pkg::ST_DET: begin
            det_in  = 1'b0;
            diff_in = '0;
            if (!polarity_ff) begin
               if (avg_ff > th) begin
                  det_in  = 1'b1;
                  diff_in = avg_ff - th;
               end
            end else begin
               if (avg_ff < th) begin
                  det_in  = 1'b1;
                  diff_in = th - avg_ff;
               end
            end
            state_in = lsatc_pkg::ST_BAR;
         end
         lsatc_pkg::ST_BAR: begin
            mul_a    = diff_ff;
            mul_b    = lsatc_pkg::BAR_RECIP;
            state_in = lsatc_pkg::ST_FIN;
         end
         lsatc_pkg::ST_FIN: begin
            quot = lsatc_pkg::fix_quot(diff_ff, prod, lsatc_pkg::BAR_STEP);
            bq   = {1'b0, quot} + (SB+1)'(1);
            o_bar_in = '0;
            if (det_ff) begin
               o_bar_in = (bq > (SB+1)'(lsatc_pkg::BAR_MAX)) ? lsatc_pkg::BAR_MAX
                                                             : lsatc_pkg::BAR_BITS'(bq);
               acc_in = acc_ff | (lsatc_pkg::FRAME_BITS'(1) << bit_idx);
            end
            // max has priority over min
            if (track_ff) begin
               if (upper_ff[pos_ff] < avg_ff) begin
                  upper_in[pos_ff] = avg_ff;
               end else if (lower_ff[pos_ff] > avg_ff) begin
                  lower_in[pos_ff] = avg_ff;
               end
            end
            o_pos_in  = lsatc_pkg::POS_BITS'(pos_ff);
            o_avg_in  = lsatc_pkg::AVG_BITS'(avg_ff);
            o_det_in  = det_ff;
            o_bits_in = '0;
            o_done_in = 1'b0;
            o_cal_in  = track_ff;
            if (ch_ff == CB'(NS - 1)) begin
               // frame close: report mask, advance history slot
               o_done_in = 1'b1;
               o_bits_in = acc_in;
               acc_in    = '0;
               if (32'(slot_ff) + 32'd1 < lsatc_pkg::HISTORY_DEPTH) begin
                  slot_in = slot_ff + lsatc_pkg::SLOT_BITS'(1);
               end else begin
                  slot_in = '0;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = lsatc_pkg::ST_IDLE;
         end
         lsatc_pkg::ST_APP: begin
            mul_a    = upper_ff[idx_ff] - lower_ff[idx_ff];
            mul_b    = lsatc_pkg::MUL_B_BITS'(f);
            state_in = lsatc_pkg::ST_APW;
         end
         lsatc_pkg::ST_APW: begin
            // crossed bounds keep the old threshold
            if (upper_ff[idx_ff] >= lower_ff[idx_ff]) begin
               thr_in[idx_ff] = lower_ff[idx_ff] + SB'(prod >> lsatc_pkg::FRAC_BITS);
            end
            if (idx_ff == CB'(NS - 1)) begin
               track_in     = 1'b0;
               o_cal_in     = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = lsatc_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + CB'(1);
               state_in = lsatc_pkg::ST_APP;
            end
         end
         default: state_in = lsatc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsatc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         track_ff     <= 1'b0;
         polarity_ff  <= 1'b0;
         factor_ff    <= lsatc_pkg::FACTOR_RESET;
         slot_ff      <= '0;
         acc_ff       <= '0;
         hvld_ff      <= '0;
         for (int j = 0; j < NS; j++) begin
            sum_ff[j]   <= '0;
            thr_ff[j]   <= lsatc_pkg::THR_RESET;
            upper_ff[j] <= '0;
            lower_ff[j] <= lsatc_pkg::SAMPLE_MAX;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         track_ff     <= track_in;
         polarity_ff  <= polarity_in;
         factor_ff    <= factor_in;
         slot_ff      <= slot_in;
         acc_ff       <= acc_in;
         hvld_ff      <= hvld_in;
         sum_ff       <= sum_in;
         thr_ff       <= thr_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      smp_ff    <= smp_in;
      old_ff    <= old_in;
      qold_ff   <= qold_in;
      avg_ff    <= avg_in;
      diff_ff   <= diff_in;
      det_ff    <= det_in;
      oldv_ff   <= oldv_in;
      o_pos_ff  <= o_pos_in;
      o_avg_ff  <= o_avg_in;
      o_det_ff  <= o_det_in;
      o_bar_ff  <= o_bar_in;
      o_bits_ff <= o_bits_in;
      o_done_ff <= o_done_in;
      o_cal_ff  <= o_cal_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsatc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsatc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsatc_alu.sv =====
// Shared multiplier with registered product, used for all divides and scaling.
// Depends on lsatc_pkg.
`default_nettype none

module lsatc_alu (
   input  wire logic                                clock,
   input  wire logic [lsatc_pkg::SAMPLE_BITS-1:0]   op_a,
   input  wire logic [lsatc_pkg::MUL_B_BITS-1:0]    op_b,
   output logic      [lsatc_pkg::PROD_BITS-1:0]     prod_ff
);

   logic [lsatc_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = lsatc_pkg::PROD_BITS'(op_a) * lsatc_pkg::PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the line sensor threshold/calibration block: random and directed command words.
// Depends on lsatc_pkg and line_sensor_array_threshold_calibrate; predicts each result in-line.
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      lsatc_pkg::op_type op;
      logic [3:0]  ch;
      logic [11:0] smp;
   } cmd_word;

   typedef struct packed {
      logic [3:0]  pos;
      logic [11:0] avg;
      logic        det;
      logic [4:0]  bar;
      logic [15:0] bits;
      logic        done;
      logic        cal;
   } line_result;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_operation;
   logic [3:0] req_channel;
   logic [11:0] req_sample;
   logic rsp_valid, rsp_stall;
   logic [3:0] rsp_position;
   logic [11:0] rsp_average;
   logic rsp_detected;
   logic [4:0] rsp_bar_level;
   logic [15:0] rsp_frame_bits;
   logic rsp_frame_done, rsp_calibrating;
   logic csr_wen;
   logic [0:0] csr_index;
   logic [8:0] csr_wdata;

   line_sensor_array_threshold_calibrate uut (.*);

   // predictor state
   logic [11:0] hist_mem [16][16];
   int          slot;
   logic [11:0] thr [16];
   logic [11:0] upper [16];
   logic [11:0] lower [16];
   logic        tracking;
   logic [15:0] bits_acc;
   logic        polarity;
   logic [8:0]  factor;

   cmd_word    pending_cmds[$];
   line_result expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit sender_hold = 0;     // pause the driver
   int long_hold = 0;       // receiver hold-off length request

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic line_result predict_line(cmd_word c);
      line_result r;
      int avg, diff, p, b;
      int unsigned f;
      r = '0;
      if (c.op == lsatc_pkg::OP_CAL_START) begin
         if (!tracking) begin
            for (int j = 0; j < 16; j++) begin
               upper[j] = '0;
               lower[j] = 12'hFFF;
            end
            tracking = 1'b1;
         end
      end else if (c.op != lsatc_pkg::OP_SAMPLE) begin
         if (tracking) begin
            if (c.op == lsatc_pkg::OP_CAL_APPLY) begin
               f = (factor > 256) ? 256 : factor;
               for (int j = 0; j < lsatc_pkg::SENSOR_COUNT; j++)
                  if (upper[j] >= lower[j])
                     thr[j] = 12'(lower[j] + (((upper[j] - lower[j]) * f) >> 8));
            end
            tracking = 1'b0;
         end
      end else begin
         hist_mem[c.ch][slot] = c.smp;
         avg = 0;
         for (int j = 0; j < lsatc_pkg::HISTORY_DEPTH; j++)
            avg += hist_mem[c.ch][j] / lsatc_pkg::HISTORY_DEPTH;
         p = c.ch[0] ? (c.ch >> 1) : (lsatc_pkg::SENSOR_COUNT - 1 - (c.ch >> 1));
         r.pos = 4'(p);
         r.avg = 12'(avg);
         diff = 0;
         if (!polarity && avg > thr[p]) begin
            r.det = 1'b1;
            diff = avg - thr[p];
         end else if (polarity && avg < thr[p]) begin
            r.det = 1'b1;
            diff = thr[p] - avg;
         end
         if (r.det) begin
            b = diff / lsatc_pkg::BAR_STEP + 1;
            r.bar = (b > 16) ? 5'd16 : 5'(b);
            bits_acc[lsatc_pkg::SENSOR_COUNT - 1 - p] = 1'b1;
         end
         if (tracking) begin
            if (upper[p] < avg) upper[p] = 12'(avg);
            else if (lower[p] > avg) lower[p] = 12'(avg);
         end
         if (c.ch == lsatc_pkg::SENSOR_COUNT - 1) begin
            r.done = 1'b1;
            r.bits = bits_acc;
            bits_acc = '0;
            slot = (slot + 1 < lsatc_pkg::HISTORY_DEPTH) ? slot + 1 : 0;
         end
      end
      r.cal = tracking;
      return r;
   endfunction

   // driver: bursts and gaps; payload held while stalled
   int gap_left = 0, burst_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_q.push_back(predict_line(pending_cmds.pop_front()));
         end
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 0;
         end else if (pending_cmds.size() > 0 && !sender_hold) begin
            req_valid <= 1;
            req_operation <= pending_cmds[0].op;
            req_channel <= pending_cmds[0].ch;
            req_sample <= pending_cmds[0].smp;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               if ($urandom_range(0, 2) != 0) gap_left = $urandom_range(0, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall pattern, plus a long hold-off on request
   int stall_mode = 0, hold_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (long_hold > 0 && hold_cnt == 0) begin
            hold_cnt = long_hold;
            long_hold = 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            rsp_stall <= 1;
         end else begin
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      line_result got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_position, rsp_average, rsp_detected, rsp_bar_level,
                 rsp_frame_bits, rsp_frame_done, rsp_calibrating};
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $display("%0t: expected pos=%0d avg=%0d det=%0d bar=%0d bits=%h done=%0d cal=%0d",
                        $time, want.pos, want.avg, want.det, want.bar, want.bits, want.done,
                        want.cal);
               $display("%0t:   actual pos=%0d avg=%0d det=%0d bar=%0d bits=%h done=%0d cal=%0d",
                        $time, got.pos, got.avg, got.det, got.bar, got.bits, got.done, got.cal);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic cmd_word mk(lsatc_pkg::op_type o, int c, int s);
      cmd_word w;
      w.op = o;
      w.ch = 4'(c);
      w.smp = 12'(s);
      return w;
   endfunction

   task automatic add_frame(int mode);
      for (int c = 0; c < 16; c++)
         pending_cmds.push_back(mk(lsatc_pkg::OP_SAMPLE, c,
            mode == 0 ? $urandom_range(0, 4095) :
            mode == 1 ? 4095 : (mode == 2 ? 0 : $urandom_range(0, 3) * 1365)));
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [8:0] v);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 0;
      if (idx == lsatc_pkg::REG_POLARITY) polarity = v[0];
      else factor = v;
   endtask

   task automatic random_phase(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70) add_frame($urandom_range(0, 3));
         else if (r < 78)
            pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_START, $urandom, $urandom));
         else if (r < 84)
            pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_APPLY, $urandom, $urandom));
         else if (r < 88)
            pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_DROP, $urandom, $urandom));
         else pending_cmds.push_back(mk(lsatc_pkg::op_type'($urandom_range(0, 3)),
                                        $urandom_range(0, 15), $urandom_range(0, 4095)));
      end
   endtask

   initial begin
      reset = 1;
      req_operation = 0; req_channel = 0; req_sample = 0;
      csr_wen = 0; csr_index = 0; csr_wdata = 0;
      for (int i = 0; i < 16; i++) begin
         thr[i] = 12'd2047; upper[i] = 0; lower[i] = 12'hFFF;
         for (int j = 0; j < 16; j++) hist_mem[i][j] = 0;
      end
      slot = 0; tracking = 0; bits_acc = 0; polarity = 0; factor = 128;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: end while idle, extremes, calibration with crossed bounds
      pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_APPLY, 0, 0));
      pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_DROP, 15, 4095));
      pending_cmds.push_back(mk(lsatc_pkg::OP_SAMPLE, 15, 4095));
      pending_cmds.push_back(mk(lsatc_pkg::OP_SAMPLE, 0, 0));
      pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_START, 0, 0));
      pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_START, 0, 0));   // start while calibrating
      pending_cmds.push_back(mk(lsatc_pkg::OP_SAMPLE, 1, 4095));
      pending_cmds.push_back(mk(lsatc_pkg::OP_SAMPLE, 1, 0));
      pending_cmds.push_back(mk(lsatc_pkg::OP_CAL_APPLY, 0, 0));   // most positions crossed
      drain();
      write_reg(lsatc_pkg::REG_FACTOR, 9'd511);                     // acts as 1.0
      write_reg(lsatc_pkg::REG_POLARITY, 9'd1);
      add_frame(1);
      add_frame(2);
      drain();

      // pressure: long receiver hold-off while sender keeps offering
      long_hold = 300;
      random_phase(8);
      drain();

      // phased settings including extremes
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(lsatc_pkg::REG_POLARITY, 9'(ph[0]));
         write_reg(lsatc_pkg::REG_FACTOR,
                   ph == 2 ? 9'd0 : ph == 3 ? 9'd256 : 9'($urandom_range(0, 511)));
         sender_hold = (ph == 4);
         if (sender_hold) begin
            drain();
            sender_hold = 0;
         end
         random_phase(7);
         drain();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
